// ----- hdl/hspd_pkg.sv -----
// Shared types, constants and helpers for the header-sync packet deframer.
`default_nettype none
package hspd_pkg;

  localparam int unsigned WordDepth = 15;
  localparam int unsigned WidxW     = $clog2(WordDepth);
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);

  localparam logic [7:0]  HdrS   = 8'h73;
  localparam logic [7:0]  HdrN   = 8'h6E;
  localparam logic [7:0]  HdrP   = 8'h70;
  localparam logic [15:0] HdrSum = 16'h0151;

  typedef logic [WidxW-1:0] widx_t;

  typedef struct packed {
    logic [7:0] ptype;
    logic [7:0] paddr;
    logic [3:0] nwords;
  } job_t;

  typedef struct packed {
    logic        en;
    widx_t       idx;
    logic [31:0] data;
  } wr_t;

  // payload byte count from the type byte: 0, 4 or 4*count
  function automatic logic [5:0] data_len(input logic [7:0] pt);
    logic [5:0] len;
    begin
      if (!pt[7]) begin
        len = 6'd0;
      end else if (pt[6]) begin
        len = {pt[5:2], 2'b00};
      end else begin
        len = 6'd4;
      end
      return len;
    end
  endfunction

endpackage
`default_nettype wire

// ----- hdl/hspd_if.sv -----
// Valid/ready channel interfaces for input bytes, results and configuration.
`default_nettype none
interface hspd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       buffer_end;
  modport source  (output valid, rx_byte, buffer_end, input ready);
  modport sink    (input valid, rx_byte, buffer_end, output ready);
  modport monitor (input valid, ready, rx_byte, buffer_end);
endinterface

interface hspd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_type;
  logic [7:0]  packet_address;
  logic [3:0]  word_count;
  logic [3:0]  word_index;
  logic [31:0] data_word;
  logic        has_word;
  logic        last;
  modport source (output valid, frame_type, packet_address, word_count, word_index,
                  data_word, has_word, last, input ready);
  modport sink   (input valid, frame_type, packet_address, word_count, word_index,
                  data_word, has_word, last, output ready);
  modport monitor (input valid, ready, frame_type, packet_address, word_count,
                   word_index, data_word, has_word, last);
endinterface

interface hspd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] match_address;
  modport source  (output valid, match_address, input ready);
  modport sink    (input valid, match_address, output ready);
  modport monitor (input valid, ready, match_address);
endinterface
`default_nettype wire

// ----- hdl/hspd_front.sv -----
// Front end: header hunt, packet parse, checksum, word assembly and job push.
`default_nettype none
module hspd_front import hspd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       buffer_end,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_match_address,
  input  logic       back_busy,
  input  logic       q_full,
  output logic       push,
  output job_t       job,
  output wr_t        wr
);

  typedef enum logic [6:0] {
    PH_HUNT   = 7'b0000001,
    PH_TYPE   = 7'b0000010,
    PH_ADDR   = 7'b0000100,
    PH_DATA   = 7'b0001000,
    PH_CKHI   = 7'b0010000,
    PH_CKLO   = 7'b0100000,
    PH_IGNORE = 7'b1000000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] recent_r, recent_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  ckhi_r, ckhi_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic [7:0]  match_r;

  logic        acc;
  logic [5:0]  len;
  logic [5:0]  cnt_inc;
  logic [15:0] sum_add;

  assign cfg_ready = 1'b1;
  // data bytes wait while the back end still reads the word store
  assign in_ready  = !((phase_r == PH_DATA) && back_busy) && !((phase_r == PH_CKLO) && q_full);
  assign acc       = in_valid && in_ready;
  assign len       = data_len(type_r);
  assign cnt_inc   = cnt_r + 6'd1;
  assign sum_add   = sum_r + {8'h00, rx_byte};
  assign job       = '{ptype: type_r, paddr: addr_r, nwords: len[5:2]};

  always_comb begin
    phase_nxt  = phase_r;
    recent_nxt = recent_r;
    type_nxt   = type_r;
    addr_nxt   = addr_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    ckhi_nxt   = ckhi_r;
    asm_nxt    = asm_r;
    push       = 1'b0;
    wr.en      = 1'b0;
    wr.idx     = cnt_r[5:2];
    wr.data    = {asm_r, rx_byte};
    if (acc) begin
      unique case (phase_r)
        PH_HUNT: begin
          if ((recent_r == {HdrS, HdrN}) && (rx_byte == HdrP)) begin
            phase_nxt = PH_TYPE;
            sum_nxt   = HdrSum;
          end
          recent_nxt = {recent_r[7:0], rx_byte};
        end
        PH_TYPE: begin
          type_nxt  = rx_byte;
          sum_nxt   = sum_add;
          phase_nxt = PH_ADDR;
        end
        PH_ADDR: begin
          addr_nxt = rx_byte;
          sum_nxt  = sum_add;
          cnt_nxt  = 6'd0;
          if (rx_byte != match_r) begin
            phase_nxt = PH_IGNORE;
          end else if (len == 6'd0) begin
            phase_nxt = PH_CKHI;
          end else begin
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          asm_nxt = {asm_r[15:0], rx_byte};
          wr.en   = (cnt_r[1:0] == 2'b11);
          sum_nxt = sum_add;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len) begin
            phase_nxt = PH_CKHI;
          end
        end
        PH_CKHI: begin
          ckhi_nxt  = rx_byte;
          phase_nxt = PH_CKLO;
        end
        PH_CKLO: begin
          push      = ({ckhi_r, rx_byte} == sum_r);
          phase_nxt = PH_IGNORE;
        end
        PH_IGNORE: begin
          phase_nxt = PH_IGNORE;
        end
        default: begin
          phase_nxt = PH_IGNORE;
        end
      endcase
      if (buffer_end) begin
        phase_nxt  = PH_HUNT;
        recent_nxt = 16'h0000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      recent_r <= '0;
      type_r   <= '0;
      addr_r   <= '0;
      cnt_r    <= '0;
      sum_r    <= '0;
      ckhi_r   <= '0;
      match_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      recent_r <= recent_nxt;
      type_r   <= type_nxt;
      addr_r   <= addr_nxt;
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
      ckhi_r   <= ckhi_nxt;
      if (cfg_valid && cfg_ready) begin
        match_r <= cfg_match_address;
      end
    end
  end

  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
  end

endmodule
`default_nettype wire

// ----- hdl/hspd_job_queue.sv -----
// Short FIFO of accepted-packet jobs between front and back ends.
`default_nettype none
module hspd_job_queue import hspd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic empty,
  output logic full
);

  localparam logic [QPtrW:0] CntFull = QPtrW'(QDepth) == '0 ? (QPtrW+1)'(QDepth)
                                                             : (QPtrW+1)'(QDepth);

  job_t             entry_r [QDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [QPtrW:0]   cnt_r;
  logic             do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CntFull);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == QPtrW'(QDepth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == QPtrW'(QDepth - 1)) ? '0 : rp_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wp_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hspd_back.sv -----
// Back end: word store and result sequencer with registered output.
`default_nettype none
module hspd_back import hspd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  wr_t         wr,
  input  logic        q_empty,
  input  job_t        q_job,
  output logic        pop,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_type,
  output logic [7:0]  packet_address,
  output logic [3:0]  word_count,
  output logic [3:0]  word_index,
  output logic [31:0] data_word,
  output logic        has_word,
  output logic        last
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_LOAD = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  logic [31:0] mem [WordDepth];
  logic [31:0] rd_r;

  state_t      state_r, state_nxt;
  job_t        job_r, job_nxt;
  widx_t       k_r, k_nxt;
  logic        valid_r, valid_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [3:0]  wc_r, wc_nxt;
  logic [3:0]  wi_r, wi_nxt;
  logic [31:0] data_r, data_nxt;
  logic        has_r, has_nxt;
  logic        last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    rd_r <= mem[k_r];
  end

  assign busy = !q_empty || (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    k_nxt     = k_r;
    valid_nxt = valid_r;
    type_nxt  = type_r;
    addr_nxt  = addr_r;
    wc_nxt    = wc_r;
    wi_nxt    = wi_r;
    data_nxt  = data_r;
    has_nxt   = has_r;
    last_nxt  = last_r;
    pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          job_nxt   = q_job;
          k_nxt     = '0;
          state_nxt = (q_job.nwords == 4'd0) ? S_LOAD : S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        valid_nxt = 1'b1;
        type_nxt  = job_r.ptype;
        addr_nxt  = job_r.paddr;
        wc_nxt    = job_r.nwords;
        wi_nxt    = k_r;
        has_nxt   = (job_r.nwords != 4'd0);
        data_nxt  = (job_r.nwords != 4'd0) ? rd_r : 32'h0;
        last_nxt  = (job_r.nwords == 4'd0) || ((k_r + 4'd1) == job_r.nwords);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready) begin
          valid_nxt = 1'b0;
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
        valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    type_r <= type_nxt;
    addr_r <= addr_nxt;
    wc_r   <= wc_nxt;
    wi_r   <= wi_nxt;
    data_r <= data_nxt;
    has_r  <= has_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign frame_type     = type_r;
  assign packet_address = addr_r;
  assign word_count     = wc_r;
  assign word_index     = wi_r;
  assign data_word      = data_r;
  assign has_word       = has_r;
  assign last           = last_r;

endmodule
`default_nettype wire

// ----- hdl/header_sync_packet_deframer_unit.sv -----
// Header-sync packet deframer top level: front parser, job queue, back sequencer.
// With the back end idle, the first result follows the low checksum byte through the
// job queue and the back-end idle, read and load states; a dataless packet skips read.
// Throughput: one byte per cycle; data bytes wait while an earlier packet drains and the
// low checksum byte waits on a full job queue; words are read, loaded, then emitted.
// Reset: synchronous active-low rst_n clears control state and match_address only.
`default_nettype none
module header_sync_packet_deframer_unit import hspd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  hspd_in_if.sink    in_ch,
  hspd_out_if.source out_ch,
  hspd_cfg_if.sink   cfg_ch
);

  logic busy;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;
  wr_t  wr;

  hspd_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .rx_byte           (in_ch.rx_byte),
    .buffer_end        (in_ch.buffer_end),
    .cfg_valid         (cfg_ch.valid),
    .cfg_ready         (cfg_ch.ready),
    .cfg_match_address (cfg_ch.match_address),
    .back_busy         (busy),
    .q_full            (q_full),
    .push              (push),
    .job               (push_job),
    .wr                (wr)
  );

  hspd_job_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  hspd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr             (wr),
    .q_empty        (q_empty),
    .q_job          (head_job),
    .pop            (pop),
    .busy           (busy),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .frame_type     (out_ch.frame_type),
    .packet_address (out_ch.packet_address),
    .word_count     (out_ch.word_count),
    .word_index     (out_ch.word_index),
    .data_word      (out_ch.data_word),
    .has_word       (out_ch.has_word),
    .last           (out_ch.last)
  );

endmodule
`default_nettype wire

// ----- hdl/hspd_checker.sv -----
// Port-level checker for the deframer result channel, bound to the top level.
`default_nettype none
module hspd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_word_count,
  input logic [3:0]  out_word_index,
  input logic [31:0] out_data_word,
  input logic        out_has_word,
  input logic        out_last
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_word)
      && $stable(out_word_index) && $stable(out_last))
    else $error("stalled result changed");

  a_word_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_word |-> (out_word_index < out_word_count)
      && (out_last == ((out_word_index + 4'd1) == out_word_count)))
    else $error("word index or last flag inconsistent with word count");

  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_word |-> out_last && (out_word_count == 4'd0)
      && (out_word_index == 4'd0) && (out_data_word == 32'h0))
    else $error("dataless result malformed");

endmodule

bind header_sync_packet_deframer_unit hspd_checker u_hspd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_word_count (out_ch.word_count),
  .out_word_index (out_ch.word_index),
  .out_data_word  (out_ch.data_word),
  .out_has_word   (out_ch.has_word),
  .out_last       (out_ch.last)
);
`default_nettype wire

// ----- tb/header_sync_packet_deframer_unit_tb.sv -----
// Self-checking testbench for the header-sync packet deframer: random byte streams vs. a predictor.
`timescale 1ns / 1ps
module header_sync_packet_deframer_unit_tb;
  import hspd_pkg::*;

  localparam int IdleLimit    = 3000;
  localparam int SettleCycles = 64;

  typedef enum logic [2:0] {
    HUNT, GET_TYPE, GET_ADDR, GET_DATA, GET_CK_HI, GET_CK_LO, SKIP_REST
  } deframe_phase_e;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_EVERY_FOURTH, RX_SPARSE} rx_stall_e;

  typedef struct packed {
    logic [7:0]  ptype;
    logic [7:0]  paddr;
    logic [3:0]  nwords;
    logic [3:0]  widx;
    logic [31:0] word;
    logic        has_word;
    logic        last;
  } deframe_result_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } rx_item_t;

  class deframe_scoreboard;
    logic [7:0]      match_addr;
    logic [15:0]     hunt_window;
    deframe_phase_e  phase;
    logic [7:0]      held_type;
    logic [7:0]      held_addr;
    logic [7:0]      ck_high;
    logic [5:0]      byte_cnt;
    logic [15:0]     run_sum;
    logic [31:0]     word_mem[15];
    deframe_result_t expected_q[$];
    int              errors;
    int              predicted_total;

    function new();
      match_addr      = '0;
      hunt_window     = '0;
      phase           = HUNT;
      held_type       = '0;
      held_addr       = '0;
      ck_high         = '0;
      byte_cnt        = '0;
      run_sum         = '0;
      errors          = 0;
      predicted_total = 0;
      foreach (word_mem[i]) word_mem[i] = '0;
    endfunction

    static function logic [5:0] payload_bytes(logic [7:0] t);
      if (!t[7]) return 6'd0;
      if (t[6]) return {t[5:2], 2'b00};
      return 6'd4;
    endfunction

    function void set_match(logic [7:0] v);
      match_addr = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [7:0] b, logic last_of_buffer);
      deframe_result_t r;
      logic [5:0]      len;
      logic [3:0]      w;
      int              k;
      case (phase)
        HUNT: begin
          if (hunt_window == {HdrS, HdrN} && b == HdrP) begin
            phase   = GET_TYPE;
            run_sum = 16'(HdrS) + 16'(HdrN) + 16'(HdrP);
          end
          hunt_window = {hunt_window[7:0], b};
        end
        GET_TYPE: begin
          held_type = b;
          run_sum   = run_sum + 16'(b);
          phase     = GET_ADDR;
        end
        GET_ADDR: begin
          held_addr = b;
          run_sum   = run_sum + 16'(b);
          byte_cnt  = '0;
          if (b != match_addr) phase = SKIP_REST;
          else if (payload_bytes(held_type) == 0) phase = GET_CK_HI;
          else phase = GET_DATA;
        end
        GET_DATA: begin
          w           = byte_cnt[5:2];
          word_mem[w] = {word_mem[w][23:0], b};
          run_sum     = run_sum + 16'(b);
          byte_cnt    = byte_cnt + 6'd1;
          if (byte_cnt >= payload_bytes(held_type)) phase = GET_CK_HI;
        end
        GET_CK_HI: begin
          ck_high = b;
          phase   = GET_CK_LO;
        end
        GET_CK_LO: begin
          if ({ck_high, b} == run_sum) begin
            len     = payload_bytes(held_type);
            r.ptype = held_type;
            r.paddr = held_addr;
            if (len == 0) begin
              r.nwords   = '0;
              r.widx     = '0;
              r.word     = '0;
              r.has_word = 1'b0;
              r.last     = 1'b1;
              expected_q.push_back(r);
              predicted_total++;
            end else begin
              for (k = 0; k < int'(len[5:2]); k++) begin
                r.nwords   = len[5:2];
                r.widx     = 4'(k);
                r.word     = word_mem[k];
                r.has_word = 1'b1;
                r.last     = (k + 1 == int'(len[5:2]));
                expected_q.push_back(r);
                predicted_total++;
              end
            end
          end
          phase = SKIP_REST;
        end
        default: phase = SKIP_REST;
      endcase
      if (last_of_buffer) begin
        phase       = HUNT;
        hunt_window = '0;
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(deframe_result_t got);
      deframe_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("frame_type", 32'(want.ptype), 32'(got.ptype));
      check_field("packet_address", 32'(want.paddr), 32'(got.paddr));
      check_field("word_count", 32'(want.nwords), 32'(got.nwords));
      check_field("word_index", 32'(want.widx), 32'(got.widx));
      check_field("data_word", want.word, got.word);
      check_field("has_word", 32'(want.has_word), 32'(got.has_word));
      check_field("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  hspd_in_if  in_ch();
  hspd_out_if out_ch();
  hspd_cfg_if cfg_ch();

  header_sync_packet_deframer_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  deframe_scoreboard sb;
  rx_item_t          stim_q[$];
  deframe_result_t   seen_result;
  int                sent_items = 0;
  int                idle_cycles = 0;
  int                mode_left = 0;
  int unsigned       beat = 0;
  rx_stall_e         stall_mode = RX_OPEN;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    beat <= beat + 1;
    if (mode_left == 0) begin
      stall_mode <= rx_stall_e'($urandom_range(0, 3));
      mode_left  <= $urandom_range(40, 240);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      RX_OPEN:         out_ch.ready <= 1'b1;
      RX_RANDOM:       out_ch.ready <= ($urandom_range(0, 2) != 0);
      RX_EVERY_FOURTH: out_ch.ready <= (beat[1:0] == 2'd3);
      default:         out_ch.ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen_result.ptype    = out_ch.frame_type;
        seen_result.paddr    = out_ch.packet_address;
        seen_result.nwords   = out_ch.word_count;
        seen_result.widx     = out_ch.word_index;
        seen_result.word     = out_ch.data_word;
        seen_result.has_word = out_ch.has_word;
        seen_result.last     = out_ch.last;
        sb.check_result(seen_result);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_input(in_ch.rx_byte, in_ch.buffer_end);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_byte(logic [7:0] b);
    rx_item_t it;
    it.rx_byte    = b;
    it.buffer_end = 1'b0;
    stim_q.push_back(it);
  endfunction

  function automatic void end_buffer();
    stim_q[stim_q.size() - 1].buffer_end = 1'b1;
  endfunction

  // biased toward header bytes so partial headers show up in noise
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return HdrS;
      1:       return HdrN;
      2:       return HdrP;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // keep < 0 sends the whole packet, otherwise only its first keep bytes
  function automatic void push_packet(logic [7:0] ptype, logic [7:0] paddr, bit bad_sum,
                                      int keep);
    logic [7:0]  pkt[$];
    logic [15:0] pkt_sum;
    int          n;
    pkt = {HdrS, HdrN, HdrP, ptype, paddr};
    n   = deframe_scoreboard::payload_bytes(ptype);
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
    pkt_sum = '0;
    foreach (pkt[i]) pkt_sum = pkt_sum + 16'(pkt[i]);
    if (bad_sum) pkt_sum = pkt_sum ^ 16'($urandom_range(1, 65535));
    pkt.push_back(pkt_sum[15:8]);
    pkt.push_back(pkt_sum[7:0]);
    if (keep < 0 || keep > pkt.size()) keep = pkt.size();
    for (int i = 0; i < keep; i++) push_byte(pkt[i]);
  endfunction

  function automatic void make_buffer(logic [7:0] match);
    int         kind;
    logic [7:0] ptype;
    kind = $urandom_range(0, 99);
    repeat ($urandom_range(0, 2)) push_byte(noise_byte());
    if (kind < 6) begin
      repeat ($urandom_range(1, 6)) push_byte(noise_byte());
    end else begin
      ptype = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0:       ptype[7] = 1'b0;
        1:       ptype[7:6] = 2'b10;
        default: begin
          ptype[7:6] = 2'b11;
          ptype[5:2] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
                                                     4'($urandom_range(0, 3));
        end
      endcase
      if (kind < 80) begin
        push_packet(ptype, match, 1'b0, -1);
      end else if (kind < 88) begin
        push_packet(ptype, match ^ 8'($urandom_range(1, 255)), 1'b0, -1);
      end else if (kind < 95) begin
        push_packet(ptype, match, 1'b1, -1);
      end else begin
        push_packet(ptype, match, 1'b0,
                    $urandom_range(1, 6 + deframe_scoreboard::payload_bytes(ptype)));
      end
      if (kind < 95) repeat ($urandom_range(0, 2)) push_byte(noise_byte());
    end
    end_buffer();
  endfunction

  task automatic drive_bytes();
    int burst;
    int gap;
    while (stim_q.size() != 0) begin
      burst = ($urandom_range(0, 4) == 0) ? 48 : $urandom_range(1, 10);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      while (burst > 0 && stim_q.size() != 0) begin
        in_ch.valid      <= 1'b1;
        in_ch.rx_byte    <= stim_q[0].rx_byte;
        in_ch.buffer_end <= stim_q[0].buffer_end;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        void'(stim_q.pop_front());
        burst--;
        sent_items++;
      end
      if (gap > 0 || stim_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_quiet();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_match(logic [7:0] v);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.match_address <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_match(v);
  endtask

  initial begin
    int         phase_idx;
    int         phase_start;
    logic [7:0] match;
    sb = new();
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.rx_byte        <= '0;
    in_ch.buffer_end     <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.match_address <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset address 0: empty packet ending on the buffer end
    push_packet(8'h00, 8'h00, 1'b0, -1);
    end_buffer();
    // header split over two buffers
    push_byte(HdrS);
    push_byte(HdrN);
    end_buffer();
    push_byte(HdrP);
    end_buffer();
    // zero-count batch, then a header left to be ignored
    push_packet(8'hC3, 8'h00, 1'b0, -1);
    push_byte(HdrS);
    end_buffer();
    // wrong address
    push_packet(8'h80, 8'h01, 1'b0, 5);
    end_buffer();
    drive_bytes();
    wait_quiet();
    write_match(8'hFF);
    push_packet(8'hBF, 8'hFF, 1'b0, -1);
    end_buffer();
    drive_bytes();

    phase_idx = 0;
    while (phase_idx < 4 || sent_items < 250) begin
      wait_quiet();
      case (phase_idx)
        0:       match = 8'h00;
        2:       match = 8'hFF;
        default: match = 8'($urandom_range(0, 255));
      endcase
      write_match(match);
      phase_start = sent_items;
      while (sent_items - phase_start < 48) begin
        make_buffer(match);
        drive_bytes();
      end
      phase_idx++;
    end

    wait_quiet();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
